>>> rtl/nearest_center_within_radius_unit_defines.svh
// assertion macros shared by the ncwr modules
`ifndef NEAREST_CENTER_WITHIN_RADIUS_UNIT_DEFINES_SVH
`define NEAREST_CENTER_WITHIN_RADIUS_UNIT_DEFINES_SVH

// consequent checked in the same cycle
`define NCWR_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ncwr check failed");

// consequent checked in the cycle after the antecedent
`define NCWR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ncwr check failed");

`endif

>>> rtl/ncwr_pkg.sv
package ncwr_pkg;

    localparam int MAX_CENTERS = 256;
    localparam int MAX_DIMS    = 3;
    localparam int MAX_VALUES  = 4;
    localparam int COORD_BITS  = 16;

    localparam int CENTER_BITS = 8;
    localparam int SLOT_BITS   = 2;
    localparam int COUNT_BITS  = 9;
    localparam int DIMS_BITS   = 2;
    localparam int NVAL_BITS   = 3;
    localparam int VALUE_BITS  = 32;
    localparam int DIST_BITS   = 34;
    localparam int SQ_BITS     = 2 * COORD_BITS + 1;
    localparam int CRD_BITS    = MAX_DIMS * COORD_BITS;
    localparam int VADDR_BITS  = CENTER_BITS + SLOT_BITS;
    localparam int ACT_BITS    = 2;

    localparam int CFG_BITS     = 34;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [ACT_BITS-1:0] ACT_COORD = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_VALUE = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_QUERY = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_CENTERS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIMS    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_VALUES  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS  = 2'd3;

    localparam logic [COUNT_BITS-1:0] CENTERS_RESET = 9'd0;
    localparam logic [DIMS_BITS-1:0]  DIMS_RESET    = 2'd2;
    localparam logic [NVAL_BITS-1:0]  VALUES_RESET  = 3'd1;
    localparam logic [DIST_BITS-1:0]  RADIUS_RESET  = 34'd65536;

    typedef struct packed {
        logic                   write_coord;
        logic                   write_value;
        logic                   latch_query;
        logic                   scan_issue;
        logic [CENTER_BITS-1:0] scan_idx;
        logic                   value_read;
        logic [SLOT_BITS-1:0]   value_slot;
        logic                   load_out;
        logic                   out_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } dp_status_t;

endpackage

>>> rtl/ncwr_ram.sv
module ncwr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/ncwr_ctrl.sv
`include "nearest_center_within_radius_unit_defines.svh"

module ncwr_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [ncwr_pkg::ACT_BITS-1:0]  action,
    input  logic [ncwr_pkg::COUNT_BITS-1:0] nc_eff,
    input  logic [ncwr_pkg::NVAL_BITS-1:0] nv_eff,
    input  ncwr_pkg::dp_status_t           status,
    output ncwr_pkg::ctrl_cmd_t            cmd
);

    import ncwr_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    state_t                 state_reg, state_next;
    logic [CENTER_BITS-1:0] idx_reg, idx_next;
    logic [SLOT_BITS-1:0]   k_reg, k_next;
    logic                   k_last;

    assign s_ready = (state_reg == ST_IDLE);
    assign k_last  = (NVAL_BITS'(k_reg) == nv_eff - NVAL_BITS'(1));

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.scan_idx   = idx_reg;
        cmd.value_slot = k_reg;
        cmd.out_last   = k_last;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    unique case (action)
                        ACT_COORD: cmd.write_coord = 1'b1;
                        ACT_VALUE: cmd.write_value = 1'b1;
                        ACT_QUERY: begin
                            cmd.latch_query = 1'b1;
                            idx_next = '0;
                            k_next   = '0;
                            state_next = (nc_eff == '0) ? ST_EMIT_RD : ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (COUNT_BITS'(idx_reg) == nc_eff - COUNT_BITS'(1)) begin
                    state_next = ST_DRAIN;
                end else begin
                    idx_next = idx_reg + CENTER_BITS'(1);
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_EMIT_RD;
                end
            end
            ST_EMIT_RD: begin
                if (status.out_free) begin
                    cmd.value_read = 1'b1;
                    state_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                cmd.load_out = 1'b1;
                if (k_last) begin
                    state_next = ST_IDLE;
                end else begin
                    k_next = k_reg + SLOT_BITS'(1);
                    state_next = ST_EMIT_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
        end
    end

    `NCWR_ASSERT_SAME(a_scan_in_range, aclk, aresetn, state_reg == ST_SCAN, COUNT_BITS'(idx_reg) < nc_eff)
    `NCWR_ASSERT_SAME(a_read_when_free, aclk, aresetn, cmd.value_read, status.out_free)
    `NCWR_ASSERT_NEXT(a_last_back_idle, aclk, aresetn, cmd.load_out && cmd.out_last, s_ready)

endmodule

>>> rtl/ncwr_datapath.sv
`include "nearest_center_within_radius_unit_defines.svh"

module ncwr_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  ncwr_pkg::ctrl_cmd_t                    cmd,
    output ncwr_pkg::dp_status_t                   status,
    input  logic [ncwr_pkg::CENTER_BITS-1:0]       entry_index,
    input  logic [ncwr_pkg::SLOT_BITS-1:0]         slot_in,
    input  logic signed [ncwr_pkg::COORD_BITS-1:0] coord_0,
    input  logic signed [ncwr_pkg::COORD_BITS-1:0] coord_1,
    input  logic signed [ncwr_pkg::COORD_BITS-1:0] coord_2,
    input  logic [ncwr_pkg::VALUE_BITS-1:0]        value_in,
    input  logic [ncwr_pkg::DIMS_BITS-1:0]         nd_eff,
    input  logic [ncwr_pkg::DIST_BITS-1:0]         radius_squared,
    input  logic                                   m_ready,
    output logic                                   m_valid,
    output logic                                   found,
    output logic [ncwr_pkg::COUNT_BITS-1:0]        center_number,
    output logic [ncwr_pkg::SLOT_BITS-1:0]         slot_out,
    output logic [ncwr_pkg::VALUE_BITS-1:0]        value_out,
    output logic                                   last
);

    import ncwr_pkg::*;

    logic signed [COORD_BITS-1:0] query_reg [MAX_DIMS];
    logic [CRD_BITS-1:0]          crd_rdata;
    logic [VALUE_BITS-1:0]        val_rdata;

    logic                         v1_reg, v2_reg;
    logic [CENTER_BITS-1:0]       idx1_reg, idx2_reg;
    logic [SQ_BITS-1:0]           sq_reg [MAX_DIMS];
    logic [SQ_BITS-1:0]           sq_next [MAX_DIMS];
    logic [DIST_BITS-1:0]         dsq;

    logic [DIST_BITS-1:0]         best_reg;
    logic [CENTER_BITS-1:0]       win_reg;
    logic                         hit_reg;

    logic                         out_valid_reg;
    logic                         out_found_reg;
    logic [COUNT_BITS-1:0]        out_center_reg;
    logic [SLOT_BITS-1:0]         out_slot_reg;
    logic [VALUE_BITS-1:0]        out_value_reg;
    logic                         out_last_reg;

    ncwr_ram #(
        .WIDTH(CRD_BITS),
        .DEPTH(MAX_CENTERS)
    ) u_coord_ram (
        .aclk  (aclk),
        .we    (cmd.write_coord),
        .waddr (entry_index),
        .wdata ({coord_2, coord_1, coord_0}),
        .re    (cmd.scan_issue),
        .raddr (cmd.scan_idx),
        .rdata (crd_rdata)
    );

    ncwr_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(MAX_CENTERS * MAX_VALUES)
    ) u_value_ram (
        .aclk  (aclk),
        .we    (cmd.write_value),
        .waddr ({entry_index, slot_in}),
        .wdata (value_in),
        .re    (cmd.value_read),
        .raddr ({win_reg, cmd.value_slot}),
        .rdata (val_rdata)
    );

    // per-axis squared difference
    always_comb begin
        logic signed [COORD_BITS:0]     d;
        logic signed [2*COORD_BITS+1:0] p;
        for (int k = 0; k < MAX_DIMS; k++) begin
            d = (COORD_BITS+1)'(query_reg[k])
                - (COORD_BITS+1)'($signed(crd_rdata[k*COORD_BITS +: COORD_BITS]));
            p = d * d;
            sq_next[k] = (k < int'(nd_eff)) ? p[SQ_BITS-1:0] : '0;
        end
    end

    always_comb begin
        dsq = '0;
        for (int k = 0; k < MAX_DIMS; k++) begin
            dsq = dsq + DIST_BITS'(sq_reg[k]);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_query) begin
            query_reg[0] <= coord_0;
            query_reg[1] <= coord_1;
            query_reg[2] <= coord_2;
        end
        idx1_reg <= cmd.scan_idx;
        idx2_reg <= idx1_reg;
        sq_reg   <= sq_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            hit_reg  <= 1'b0;
            win_reg  <= '0;
            best_reg <= '0;
        end else begin
            v1_reg <= cmd.scan_issue;
            v2_reg <= v1_reg;
            if (cmd.latch_query) begin
                best_reg <= radius_squared;
                win_reg  <= '0;
                hit_reg  <= 1'b0;
            end else if (v2_reg && (dsq < best_reg)) begin
                best_reg <= dsq;
                win_reg  <= idx2_reg;
                hit_reg  <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_found_reg  <= hit_reg;
            out_center_reg <= hit_reg ? COUNT_BITS'(win_reg) + COUNT_BITS'(1) : '0;
            out_slot_reg   <= cmd.value_slot;
            out_value_reg  <= hit_reg ? val_rdata : '0;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign status.pipe_busy = v1_reg | v2_reg;
    assign status.out_free  = !out_valid_reg | m_ready;

    assign m_valid       = out_valid_reg;
    assign found         = out_found_reg;
    assign center_number = out_center_reg;
    assign slot_out      = out_slot_reg;
    assign value_out     = out_value_reg;
    assign last          = out_last_reg;

    `NCWR_ASSERT_SAME(a_load_into_empty, aclk, aresetn, cmd.load_out, !out_valid_reg)
    `NCWR_ASSERT_SAME(a_scan_done_before_read, aclk, aresetn, cmd.value_read, !status.pipe_busy)
    `NCWR_ASSERT_SAME(a_miss_is_zero, aclk, aresetn, out_valid_reg && !out_found_reg, out_center_reg == '0 && out_value_reg == '0)

endmodule

>>> rtl/nearest_center_within_radius_unit.sv
// load requests: accepted while idle, no result
// query: scans N = centers_in_use centers, one per cycle over the coordinate memory read port,
//   then reads and outputs each value word in turn, waiting while the output is held
// a new request is accepted only after the last value word of a query has been loaded
// reset: synchronous active-low aresetn clears control and the registers to their defaults;
//   the center memories are not cleared
module nearest_center_within_radius_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // entry_index, slot_in, coord_0, coord_1, coord_2, value_in, zero pad
    input  logic [95:0]                          s_axis_tdata,
    // action
    input  logic [ncwr_pkg::ACT_BITS-1:0]        s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // center_number, slot_out, value_out, zero pad
    output logic [47:0]                          m_axis_tdata,
    // found
    output logic                                 m_axis_tuser,
    output logic                                 m_axis_tlast,
    input  logic                                 cfg_we,
    input  logic [ncwr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [ncwr_pkg::CFG_BITS-1:0]        cfg_data
);

    import ncwr_pkg::*;

    logic [COUNT_BITS-1:0] centers_reg;
    logic [DIMS_BITS-1:0]  dims_reg;
    logic [NVAL_BITS-1:0]  values_reg;
    logic [DIST_BITS-1:0]  radius_reg;

    logic [COUNT_BITS-1:0] nc_eff;
    logic [DIMS_BITS-1:0]  nd_eff;
    logic [NVAL_BITS-1:0]  nv_eff;

    ctrl_cmd_t             cmd;
    dp_status_t            status;

    logic [COUNT_BITS-1:0] center_number;
    logic [SLOT_BITS-1:0]  slot_out;
    logic [VALUE_BITS-1:0] value_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centers_reg <= CENTERS_RESET;
            dims_reg    <= DIMS_RESET;
            values_reg  <= VALUES_RESET;
            radius_reg  <= RADIUS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CENTERS: centers_reg <= cfg_data[COUNT_BITS-1:0];
                REG_DIMS:    dims_reg    <= cfg_data[DIMS_BITS-1:0];
                REG_VALUES:  values_reg  <= cfg_data[NVAL_BITS-1:0];
                REG_RADIUS:  radius_reg  <= cfg_data[DIST_BITS-1:0];
                default: ;
            endcase
        end
    end

    // clamp centers, dims and values to the table limits; zero dims or values read as one
    always_comb begin
        nc_eff = (centers_reg > COUNT_BITS'(MAX_CENTERS)) ? COUNT_BITS'(MAX_CENTERS)
                                                           : centers_reg;
        if (dims_reg == '0) begin
            nd_eff = DIMS_BITS'(1);
        end else if (int'(dims_reg) > MAX_DIMS) begin
            nd_eff = DIMS_BITS'(MAX_DIMS);
        end else begin
            nd_eff = dims_reg;
        end
        if (values_reg == '0) begin
            nv_eff = NVAL_BITS'(1);
        end else if (int'(values_reg) > MAX_VALUES) begin
            nv_eff = NVAL_BITS'(MAX_VALUES);
        end else begin
            nv_eff = values_reg;
        end
    end

    ncwr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .action  (s_axis_tuser),
        .nc_eff  (nc_eff),
        .nv_eff  (nv_eff),
        .status  (status),
        .cmd     (cmd)
    );

    ncwr_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .entry_index    (s_axis_tdata[7:0]),
        .slot_in        (s_axis_tdata[9:8]),
        .coord_0        (s_axis_tdata[25:10]),
        .coord_1        (s_axis_tdata[41:26]),
        .coord_2        (s_axis_tdata[57:42]),
        .value_in       (s_axis_tdata[89:58]),
        .nd_eff         (nd_eff),
        .radius_squared (radius_reg),
        .m_ready        (m_axis_tready),
        .m_valid        (m_axis_tvalid),
        .found          (m_axis_tuser),
        .center_number  (center_number),
        .slot_out       (slot_out),
        .value_out      (value_out),
        .last           (m_axis_tlast)
    );

    assign m_axis_tdata = {5'b0, value_out, slot_out, center_number};

endmodule

>>> dv/nearest_center_within_radius_unit_tb.sv
`timescale 1ns / 100ps

module nearest_center_within_radius_unit_tb;
    import ncwr_pkg::*;

    localparam logic [ACT_BITS-1:0]  ACT_UNUSED   = 2'd3;
    localparam logic [DIST_BITS-1:0] RADIUS_MAX   = '1;
    localparam int                   HOLD_CYCLES  = 1500;
    localparam int                   DRAIN_CYCLES = 16;
    localparam int                   CYCLE_LIMIT  = 1500000;

    // request as it travels: entry, slot, coords, value packed from the lowest bit up
    typedef struct packed {
        logic [ACT_BITS-1:0]                 action;
        logic [VALUE_BITS-1:0]               value;
        logic [MAX_DIMS-1:0][COORD_BITS-1:0] crd;
        logic [SLOT_BITS-1:0]                slot;
        logic [CENTER_BITS-1:0]              entry;
    } request_t;

    typedef struct packed {
        logic                  found;
        logic [COUNT_BITS-1:0] number;
        logic [SLOT_BITS-1:0]  slot;
        logic [VALUE_BITS-1:0] value;
        logic                  last;
    } value_word_t;

    logic                    aclk = 1'b0;
    logic                    aresetn;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [95:0]             s_axis_tdata;
    logic [ACT_BITS-1:0]     s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [47:0]             m_axis_tdata;
    logic                    m_axis_tuser;
    logic                    m_axis_tlast;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;

    // shadow of the center table and the registers
    logic [COORD_BITS-1:0] center_crd [MAX_CENTERS][MAX_DIMS];
    logic [VALUE_BITS-1:0] center_val [MAX_CENTERS][MAX_VALUES];
    bit                    val_known  [MAX_CENTERS][MAX_VALUES];
    logic [COUNT_BITS-1:0] n_centers;
    logic [DIMS_BITS-1:0]  n_dims;
    logic [NVAL_BITS-1:0]  n_values;
    logic [DIST_BITS-1:0]  radius_sq;

    value_word_t pending_words [$];
    int          fail_count  = 0;
    int          cycle_count = 0;
    bit          steady;
    bit          stall_request;

    nearest_center_within_radius_unit u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic int value_count();
        int nv;
        nv = (n_values == 0) ? 1 : n_values;
        if (nv > MAX_VALUES) nv = MAX_VALUES;
        return nv;
    endfunction

    // winning entry of a query against the shadow table, -1 when nothing is in range
    function automatic int nearest_entry(request_t r);
        int     nc;
        int     nd;
        int     win;
        longint best;
        longint dsq;
        longint d;
        nc = (n_centers > MAX_CENTERS) ? MAX_CENTERS : n_centers;
        nd = (n_dims == 0) ? 1 : n_dims;
        if (nd > MAX_DIMS) nd = MAX_DIMS;
        best = longint'(radius_sq);
        win  = -1;
        for (int ic = 0; ic < nc; ic++) begin
            dsq = 0;
            for (int k = 0; k < nd; k++) begin
                d = longint'($signed(r.crd[k])) - longint'($signed(center_crd[ic][k]));
                dsq += d * d;
            end
            if (dsq < best) begin
                best = dsq;
                win  = ic;
            end
        end
        return win;
    endfunction

    // updates the table on loads, and on a query queues the words of the nearest center or not-found words
    function automatic void apply_to_table(request_t r);
        int          nv;
        int          win;
        bit          hit;
        value_word_t w;
        case (r.action)
            ACT_COORD: begin
                for (int k = 0; k < MAX_DIMS; k++) center_crd[r.entry][k] = r.crd[k];
            end
            ACT_VALUE: begin
                center_val[r.entry][r.slot] = r.value;
                val_known[r.entry][r.slot]  = 1'b1;
            end
            ACT_QUERY: begin
                nv  = value_count();
                win = nearest_entry(r);
                hit = (win >= 0);
                for (int k = 0; k < nv; k++) begin
                    w.found  = hit;
                    w.number = '0;
                    w.value  = '0;
                    if (hit) begin
                        w.number = COUNT_BITS'(win + 1);
                        w.value  = center_val[win][k];
                    end
                    w.slot   = SLOT_BITS'(k);
                    w.last   = (k == nv - 1);
                    pending_words.push_back(w);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic request_t make_request(logic [ACT_BITS-1:0] action,
                                              logic [CENTER_BITS-1:0] entry,
                                              logic [SLOT_BITS-1:0] slot,
                                              logic [COORD_BITS-1:0] c0, c1, c2,
                                              logic [VALUE_BITS-1:0] value);
        request_t r;
        r.action = action;
        r.entry  = entry;
        r.slot   = slot;
        r.crd    = {c2, c1, c0};
        r.value  = value;
        return r;
    endfunction

    function automatic request_t random_load();
        request_t r;
        r.action = $urandom_range(0, 1) ? ACT_VALUE : ACT_COORD;
        r.entry  = CENTER_BITS'($urandom);
        r.slot   = SLOT_BITS'($urandom);
        r.crd    = {COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom)};
        r.value  = $urandom;
        return r;
    endfunction

    // mostly near a center in use, so that the radius comes into play
    function automatic request_t random_query();
        request_t r;
        int       nc;
        int       ic;
        int       spread;
        r = random_load();
        r.action = ACT_QUERY;
        if ($urandom_range(99) < 65) begin
            nc     = (n_centers > MAX_CENTERS) ? MAX_CENTERS : n_centers;
            ic     = (nc == 0) ? 0 : $urandom_range(0, nc - 1);
            spread = 1 << $urandom_range(0, 12);
            for (int k = 0; k < MAX_DIMS; k++)
                r.crd[k] = center_crd[ic][k] + COORD_BITS'($urandom_range(0, 2 * spread))
                           - COORD_BITS'(spread);
        end
        return r;
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_radius();
        case ($urandom_range(0, 4))
            0: return {2'($urandom_range(0, 3)), 32'($urandom)};
            1: return CFG_BITS'($urandom_range(1, 1 << 16));
            2: return CFG_BITS'($urandom_range(1 << 16, 1 << 26));
            3: return RADIUS_MAX;
            default: return CFG_BITS'($urandom_range(0, 64));
        endcase
    endfunction

    function automatic int unsigned pick_centers();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5) return 0;
        if (roll < 10) return $urandom_range(MAX_CENTERS, 511);
        if (roll < 22) return $urandom_range(33, MAX_CENTERS);
        return $urandom_range(1, 32);
    endfunction

    task automatic send_request(request_t r);
        int gap;
        gap = (!steady && $urandom_range(99) < 37) ? $urandom_range(1, 4) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.action;
        s_axis_tdata  <= {6'b0, r.value, r.crd, r.slot, r.entry};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        apply_to_table(r);
    endtask

    // loads any value word that the winner still lacks, then sends the query
    task automatic send_query(request_t r);
        int win;
        win = nearest_entry(r);
        if (win >= 0) begin
            for (int k = 0; k < value_count(); k++) begin
                if (!val_known[win][k])
                    send_request(make_request(ACT_VALUE, CENTER_BITS'(win), SLOT_BITS'(k),
                                              '0, '0, '0, $urandom));
            end
        end
        send_request(r);
    endtask

    task automatic ask_nearest(logic [COORD_BITS-1:0] c0, c1, c2);
        send_request(make_request(ACT_QUERY, '0, '0, c0, c1, c2, '0));
    endtask

    // stop offering and wait for the block to drain
    task automatic settle();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
    endtask

    task automatic configure(int unsigned centers, int unsigned dims, int unsigned values,
                             logic [CFG_BITS-1:0] radius);
        cfg_write(REG_CENTERS, CFG_BITS'(centers));
        cfg_write(REG_DIMS, CFG_BITS'(dims));
        cfg_write(REG_VALUES, CFG_BITS'(values));
        cfg_write(REG_RADIUS, radius);
        @(negedge aclk);
        cfg_we    <= 1'b0;
        n_centers = COUNT_BITS'(centers);
        n_dims    = DIMS_BITS'(dims);
        n_values  = NVAL_BITS'(values);
        radius_sq = radius;
    endtask

    task automatic test_empty_table();
        request_t r;
        ask_nearest(COORD_BITS'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom));
        r = random_load();
        r.action = ACT_UNUSED;
        send_request(r);
        settle();
    endtask

    task automatic test_directed_extremes();
        logic [VALUE_BITS-1:0] v;
        configure(3, 3, 4, RADIUS_MAX);
        send_request(make_request(ACT_COORD, 8'd0, '0, 16'h8000, 16'h8000, 16'h8000, '0));
        send_request(make_request(ACT_COORD, 8'd1, '0, 16'h7FFF, 16'h7FFF, 16'h7FFF, '0));
        send_request(make_request(ACT_COORD, 8'd2, '0, 16'h7FFF, 16'h7FFF, 16'h7FFF, '0));
        for (int e = 0; e < 3; e++) begin
            for (int s = 0; s < MAX_VALUES; s++) begin
                v = (s == 0) ? 32'h0 : (s == MAX_VALUES - 1) ? 32'hFFFF_FFFF : $urandom;
                send_request(make_request(ACT_VALUE, CENTER_BITS'(e), SLOT_BITS'(s),
                                          '0, '0, '0, v));
            end
        end
        // tie at distance zero, lower entry wins
        ask_nearest(16'h7FFF, 16'h7FFF, 16'h7FFF);
        ask_nearest(16'h8000, 16'h8000, 16'h8000);
        ask_nearest(16'h0000, 16'h0000, 16'h0000);
        settle();
        // largest possible distance still inside the largest radius
        configure(1, 3, 4, RADIUS_MAX);
        ask_nearest(16'h7FFF, 16'h7FFF, 16'h7FFF);
        settle();
        configure(3, 3, 4, 0);
        ask_nearest(16'h7FFF, 16'h7FFF, 16'h7FFF);
        settle();
        // zero dims and zero values act as one
        configure(3, 0, 0, 1);
        ask_nearest(16'h8000, 16'h1234, 16'h5678);
        settle();
        configure(3, 2, 7, 100);
        ask_nearest(16'h0000, 16'h0000, 16'h0000);
        ask_nearest(16'h7FFF, 16'h7FFA, 16'h0000);
        settle();
    endtask

    task automatic test_full_table();
        for (int e = 0; e < MAX_CENTERS; e++) begin
            send_request(make_request(ACT_COORD, CENTER_BITS'(e), '0, COORD_BITS'($urandom),
                                      COORD_BITS'($urandom), COORD_BITS'($urandom), '0));
        end
        settle();
        configure(MAX_CENTERS, 2, 4, 34'd1 << 24);
        repeat (4) send_query(random_query());
        settle();
        // centers above the table size saturate
        configure(511, 3, 4, RADIUS_MAX);
        repeat (3) send_query(random_query());
        settle();
    endtask

    task automatic test_backpressure();
        configure(8, 2, 4, RADIUS_MAX);
        stall_request = 1'b1;
        repeat (6) send_query(random_query());
        settle();
    endtask

    task automatic test_random_mix();
        request_t r;
        for (int phase = 0; phase < 8; phase++) begin
            steady = (phase == 1);
            configure(pick_centers(), $urandom_range(0, 3), $urandom_range(0, 7), pick_radius());
            for (int i = 0; i < 5; i++) begin
                if ($urandom_range(99) < 5) begin
                    r = random_load();
                    r.action = ACT_UNUSED;
                    send_request(r);
                end
                if ($urandom_range(99) < 62) send_query(random_query());
                else send_request(random_load());
            end
            settle();
        end
        steady = 1'b0;
    endtask

    initial begin : result_sink
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_request) begin
                stall_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= 37);
            end
        end
    end

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : word_check
        value_word_t w;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_words.size() == 0) begin
                $error("result word with no query pending");
                fail_count++;
            end else begin
                w = pending_words.pop_front();
                check_field("found", w.found, m_axis_tuser);
                check_field("center_number", w.number, m_axis_tdata[8:0]);
                check_field("slot_out", w.slot, m_axis_tdata[10:9]);
                check_field("value_out", w.value, m_axis_tdata[42:11]);
                check_field("last", w.last, m_axis_tlast);
            end
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        steady        = 1'b0;
        stall_request = 1'b0;
        n_centers     = CENTERS_RESET;
        n_dims        = DIMS_RESET;
        n_values      = VALUES_RESET;
        radius_sq     = RADIUS_RESET;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_table();
        test_directed_extremes();
        test_full_table();
        test_backpressure();
        test_random_mix();
        settle();

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
